FILE: rtl/core/macm_pkg.sv
// Shared types, constants and helpers for the multi-pattern automaton matcher.
// No dependencies; used by macm_ctrl and the matcher top in rtl/core.
package macm_pkg;

  localparam int unsigned MAX_NODES   = 1024;
  localparam int unsigned ALPHABET    = 26;
  localparam int unsigned NODE_W      = $clog2(MAX_NODES);
  localparam int unsigned CNT_W       = NODE_W + 1;
  localparam int unsigned SYM_W       = 5;
  localparam int unsigned LET_W       = $clog2(ALPHABET);
  localparam int unsigned CHILD_DEPTH = MAX_NODES * ALPHABET;
  localparam int unsigned CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int unsigned CHILD_W     = NODE_W + 1;  // {valid, node}
  localparam int unsigned TOT_W       = 16;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_BUILD  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BUILT   = 2'd2,
    ST_UNBUILT = 2'd3
  } stat_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_INS_LOOK,
    S_CLR_ROW,
    S_INS_END,
    S_INS_INC,
    S_BLD_ROOT,
    S_BLD_POP,
    S_BLD_NOW,
    S_BLD_F,
    S_BLD_RDE,
    S_BLD_RDF,
    S_BLD_WR,
    S_Q_LOOK,
    S_Q_WALK,
    S_Q_ACC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [TOT_W-1:0] count;
    logic             final_flag;
    stat_e            status;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [CHILD_AW-1:0] waddr;
    logic [CHILD_W-1:0]  wdata;
    logic                re;
    logic [CHILD_AW-1:0] raddr;
  } child_port_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } nptr_port_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [TOT_W-1:0]  wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } ends_port_t;

  function automatic logic [CHILD_AW-1:0] child_addr(logic [NODE_W-1:0] node,
                                                     logic [LET_W-1:0] lt);
    return CHILD_AW'(node) * CHILD_AW'(ALPHABET) + CHILD_AW'(lt);
  endfunction

  function automatic logic [TOT_W-1:0] sat_add16(logic [TOT_W-1:0] a,
                                                 logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/multi_pattern_automaton_matcher_unit.sv
// Multi-pattern automaton matcher: one item in flight, results via an output register.
// Insert clears a new node's row when it allocates one; a query walks the failure chain
// from the reached node; build walks every trie node breadth-first unless already built.
// One item at a time: the next transfer waits until the sequencer has handed its result on.
// Reset (async, active low) empties the trie and clears the built flag; no memory sweep.
// Depends on macm_pkg, macm_ram and macm_ctrl.
module multi_pattern_automaton_matcher_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [macm_pkg::SYM_W-1:0] symbol_i,
  input  logic                       first_of_string_i,
  input  logic                       last_of_string_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [macm_pkg::TOT_W-1:0] match_count_o,
  output logic                       count_final_o,
  output logic [1:0]                 status_o
);
  import macm_pkg::*;

  child_port_t        child_p;
  nptr_port_t         fail_p, queue_p;
  ends_port_t         ends_p;
  logic [CHILD_W-1:0] child_rdata;
  logic [NODE_W-1:0]  fail_rdata, queue_rdata;
  logic [TOT_W-1:0]   ends_rdata;
  logic               res_valid, res_ready;
  res_t               res;

  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  macm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .idle_o        (in_ready_o),
    .req_type_i,
    .symbol_i,
    .first_i       (first_of_string_i),
    .last_i        (last_of_string_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .child_o       (child_p),
    .child_rdata_i (child_rdata),
    .fail_o        (fail_p),
    .fail_rdata_i  (fail_rdata),
    .queue_o       (queue_p),
    .queue_rdata_i (queue_rdata),
    .ends_o        (ends_p),
    .ends_rdata_i  (ends_rdata)
  );

  macm_ram #(.WIDTH(CHILD_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
    .clk_i,
    .we_i    (child_p.we),
    .waddr_i (child_p.waddr),
    .wdata_i (child_p.wdata),
    .re_i    (child_p.re),
    .raddr_i (child_p.raddr),
    .rdata_o (child_rdata)
  );

  macm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail_ram (
    .clk_i,
    .we_i    (fail_p.we),
    .waddr_i (fail_p.waddr),
    .wdata_i (fail_p.wdata),
    .re_i    (fail_p.re),
    .raddr_i (fail_p.raddr),
    .rdata_o (fail_rdata)
  );

  macm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk_i,
    .we_i    (queue_p.we),
    .waddr_i (queue_p.waddr),
    .wdata_i (queue_p.wdata),
    .re_i    (queue_p.re),
    .raddr_i (queue_p.raddr),
    .rdata_o (queue_rdata)
  );

  macm_ram #(.WIDTH(TOT_W), .DEPTH(MAX_NODES)) u_ends_ram (
    .clk_i,
    .we_i    (ends_p.we),
    .waddr_i (ends_p.waddr),
    .wdata_i (ends_p.wdata),
    .re_i    (ends_p.re),
    .raddr_i (ends_p.raddr),
    .rdata_o (ends_rdata)
  );

  // output register: a result waits here while the next item is taken
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_res_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = out_res_q.count;
  assign count_final_o = out_res_q.final_flag;
  assign status_o      = out_res_q.status;

  // a closing query result is always a good one
  a_final_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_final_o |-> status_o == ST_OK)
    else $error("count_final with error status");

  // an error result carries no count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> match_count_o == '0)
    else $error("nonzero count on error result");

  // one item in flight: no transfer in the cycle after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

FILE: rtl/core/macm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module macm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/macm_ctrl.sv
// Sequencer for the matcher: clear, trie insert, breadth-first link build and query walk.
// Depends on macm_pkg; drives the child, fail, queue and end-count memories.
module macm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          idle_o,
  input  logic [1:0]                    req_type_i,
  input  logic [macm_pkg::SYM_W-1:0]    symbol_i,
  input  logic                          first_i,
  input  logic                          last_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output macm_pkg::res_t                res_o,
  output macm_pkg::child_port_t         child_o,
  input  logic [macm_pkg::CHILD_W-1:0]  child_rdata_i,
  output macm_pkg::nptr_port_t          fail_o,
  input  logic [macm_pkg::NODE_W-1:0]   fail_rdata_i,
  output macm_pkg::nptr_port_t          queue_o,
  input  logic [macm_pkg::NODE_W-1:0]   queue_rdata_i,
  output macm_pkg::ends_port_t          ends_o,
  input  logic [macm_pkg::TOT_W-1:0]    ends_rdata_i
);
  import macm_pkg::*;

  state_e              state_q, state_d;
  req_e                req_q, req_d;
  logic [SYM_W-1:0]    sym_q, sym_d;
  logic                first_q, first_d, last_q, last_d;
  logic [NODE_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]    ncount_q, ncount_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic                built_q, built_d, dropped_q, dropped_d;
  logic [ALPHABET-1:0] root_valid_q, root_valid_d;
  logic [NODE_W-1:0]   root_child_q [ALPHABET];
  logic [NODE_W-1:0]   root_child_d [ALPHABET];
  logic [LET_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0]   now_q, now_d, f_q, f_d, t_q, t_d, newn_q, newn_d;
  logic [CHILD_W-1:0]  ce_q, ce_d;
  res_t                res_q, res_d;

  logic [LET_W-1:0]  let_ix, root_ix;
  logic              sym_ok, can_alloc, rd_hit, root_hit, last_ix, ins_walk, eff_drop;
  logic [NODE_W-1:0] eff_cur, root_node, cf;

  assign let_ix    = sym_q[LET_W-1:0];
  assign sym_ok    = sym_q < SYM_W'(ALPHABET);
  assign can_alloc = ncount_q < CNT_W'(MAX_NODES);
  assign rd_hit    = child_rdata_i[NODE_W];
  assign root_ix   = (state_q == S_DECODE) ? let_ix : idx_q;
  assign root_hit  = root_valid_q[root_ix];
  assign root_node = root_child_q[root_ix];
  assign last_ix   = idx_q == LET_W'(ALPHABET - 1);
  assign eff_cur   = first_q ? '0 : cur_q;
  assign eff_drop  = first_q ? 1'b0 : dropped_q;
  assign ins_walk  = !eff_drop && sym_ok;
  assign cf        = (f_q == '0) ? root_node : child_rdata_i[NODE_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        unique case (req_q)
          REQ_CLEAR:  state_d = S_DONE;
          REQ_INSERT: begin
            if (built_q) state_d = S_DONE;
            else if (!ins_walk) state_d = S_INS_END;
            else if (eff_cur != '0) state_d = S_INS_LOOK;
            else if (root_hit || !can_alloc) state_d = S_INS_END;
            else state_d = S_CLR_ROW;
          end
          REQ_BUILD:  state_d = built_q ? S_DONE : S_BLD_ROOT;
          REQ_QUERY: begin
            if (!built_q || !sym_ok) state_d = S_DONE;
            else if (eff_cur == '0) state_d = S_Q_WALK;
            else state_d = S_Q_LOOK;
          end
          default:    state_d = S_DONE;
        endcase
      end
      S_INS_LOOK: state_d = (rd_hit || !can_alloc) ? S_INS_END : S_CLR_ROW;
      S_CLR_ROW:  if (last_ix) state_d = S_INS_END;
      S_INS_END:  state_d = (!dropped_q && last_q) ? S_INS_INC : S_DONE;
      S_INS_INC:  state_d = S_DONE;
      S_BLD_ROOT: if (last_ix) state_d = S_BLD_POP;
      S_BLD_POP:  state_d = (head_q == tail_q) ? S_DONE : S_BLD_NOW;
      S_BLD_NOW:  state_d = S_BLD_F;
      S_BLD_F:    state_d = S_BLD_RDE;
      S_BLD_RDE:  state_d = S_BLD_RDF;
      S_BLD_RDF:  state_d = S_BLD_WR;
      S_BLD_WR:   state_d = last_ix ? S_BLD_POP : S_BLD_RDE;
      S_Q_LOOK:   state_d = S_Q_WALK;
      S_Q_WALK:   state_d = (t_q == '0) ? S_DONE : S_Q_ACC;
      S_Q_ACC:    state_d = S_Q_WALK;
      S_DONE:     if (res_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    req_d        = req_q;
    sym_d        = sym_q;
    first_d      = first_q;
    last_d       = last_q;
    cur_d        = cur_q;
    ncount_d     = ncount_q;
    total_d      = total_q;
    built_d      = built_q;
    dropped_d    = dropped_q;
    root_valid_d = root_valid_q;
    root_child_d = root_child_q;
    idx_d        = idx_q;
    head_d       = head_q;
    tail_d       = tail_q;
    now_d        = now_q;
    f_d          = f_q;
    t_d          = t_q;
    newn_d       = newn_q;
    ce_d         = ce_q;
    res_d        = res_q;
    child_o      = '0;
    fail_o       = '0;
    queue_o      = '0;
    ends_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        req_d   = req_e'(req_type_i);
        sym_d   = symbol_i;
        first_d = first_i;
        last_d  = last_i;
      end
      S_DECODE: begin
        res_d = '0;
        unique case (req_q)
          REQ_CLEAR: begin
            ncount_d     = CNT_W'(1);
            cur_d        = '0;
            total_d      = '0;
            built_d      = 1'b0;
            dropped_d    = 1'b0;
            root_valid_d = '0;
          end
          REQ_INSERT: begin
            if (built_q) begin
              res_d.status = ST_BUILT;
            end else begin
              cur_d     = eff_cur;
              dropped_d = eff_drop;
              if (ins_walk) begin
                if (eff_cur != '0) begin
                  child_o.re    = 1'b1;
                  child_o.raddr = child_addr(eff_cur, let_ix);
                end else if (root_hit) begin
                  cur_d = root_node;
                end else if (can_alloc) begin
                  root_valid_d[root_ix] = 1'b1;
                  root_child_d[root_ix] = ncount_q[NODE_W-1:0];
                  newn_d   = ncount_q[NODE_W-1:0];
                  ncount_d = ncount_q + 1'b1;
                  idx_d    = '0;
                end else begin
                  dropped_d = 1'b1;
                end
              end
            end
          end
          REQ_BUILD: begin
            idx_d  = '0;
            head_d = '0;
            tail_d = '0;
          end
          REQ_QUERY: begin
            if (!built_q) begin
              res_d.status = ST_UNBUILT;
            end else begin
              total_d = first_q ? '0 : total_q;
              if (!sym_ok) begin
                cur_d            = '0;
                res_d.count      = first_q ? '0 : total_q;
                res_d.final_flag = last_q;
              end else if (eff_cur == '0) begin
                cur_d = root_node;
                t_d   = root_node;
              end else begin
                child_o.re    = 1'b1;
                child_o.raddr = child_addr(eff_cur, let_ix);
              end
            end
          end
          default: ;
        endcase
      end
      S_INS_LOOK: begin
        if (rd_hit) begin
          cur_d = child_rdata_i[NODE_W-1:0];
        end else if (can_alloc) begin
          child_o.we    = 1'b1;
          child_o.waddr = child_addr(cur_q, let_ix);
          child_o.wdata = {1'b1, ncount_q[NODE_W-1:0]};
          newn_d   = ncount_q[NODE_W-1:0];
          ncount_d = ncount_q + 1'b1;
          idx_d    = '0;
        end else begin
          dropped_d = 1'b1;
        end
      end
      S_CLR_ROW: begin
        // wipe the new node's row, end count and link
        child_o.we    = 1'b1;
        child_o.waddr = child_addr(newn_q, idx_q);
        child_o.wdata = '0;
        if (idx_q == '0) begin
          ends_o.we    = 1'b1;
          ends_o.waddr = newn_q;
          fail_o.we    = 1'b1;
          fail_o.waddr = newn_q;
        end
        if (last_ix) cur_d = newn_q;
        else idx_d = idx_q + 1'b1;
      end
      S_INS_END: begin
        if (dropped_q) begin
          res_d.status = ST_FULL;
        end else if (last_q) begin
          ends_o.re    = 1'b1;
          ends_o.raddr = cur_q;
        end
      end
      S_INS_INC: begin
        ends_o.we    = 1'b1;
        ends_o.waddr = cur_q;
        ends_o.wdata = sat_add16(ends_rdata_i, TOT_W'(1));
      end
      S_BLD_ROOT: begin
        if (!root_hit) begin
          root_valid_d[root_ix] = 1'b1;
          root_child_d[root_ix] = '0;
        end else begin
          fail_o.we     = 1'b1;
          fail_o.waddr  = root_node;
          queue_o.we    = 1'b1;
          queue_o.waddr = tail_q[NODE_W-1:0];
          queue_o.wdata = root_node;
          tail_d        = tail_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
      end
      S_BLD_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
        end else begin
          queue_o.re    = 1'b1;
          queue_o.raddr = head_q[NODE_W-1:0];
          head_d        = head_q + 1'b1;
        end
      end
      S_BLD_NOW: begin
        now_d        = queue_rdata_i;
        fail_o.re    = 1'b1;
        fail_o.raddr = queue_rdata_i;
      end
      S_BLD_F: begin
        f_d   = fail_rdata_i;
        idx_d = '0;
      end
      S_BLD_RDE: begin
        child_o.re    = 1'b1;
        child_o.raddr = child_addr(now_q, idx_q);
      end
      S_BLD_RDF: begin
        ce_d = child_rdata_i;
        if (f_q != '0) begin
          child_o.re    = 1'b1;
          child_o.raddr = child_addr(f_q, idx_q);
        end
      end
      S_BLD_WR: begin
        // the link target's row is complete: it was walked earlier
        if (!ce_q[NODE_W]) begin
          child_o.we    = 1'b1;
          child_o.waddr = child_addr(now_q, idx_q);
          child_o.wdata = {1'b1, cf};
        end else begin
          fail_o.we     = 1'b1;
          fail_o.waddr  = ce_q[NODE_W-1:0];
          fail_o.wdata  = cf;
          queue_o.we    = 1'b1;
          queue_o.waddr = tail_q[NODE_W-1:0];
          queue_o.wdata = ce_q[NODE_W-1:0];
          tail_d        = tail_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
      end
      S_Q_LOOK: begin
        cur_d = rd_hit ? child_rdata_i[NODE_W-1:0] : '0;
        t_d   = rd_hit ? child_rdata_i[NODE_W-1:0] : '0;
      end
      S_Q_WALK: begin
        if (t_q == '0) begin
          res_d.count      = total_q;
          res_d.final_flag = last_q;
        end else begin
          ends_o.re    = 1'b1;
          ends_o.raddr = t_q;
          fail_o.re    = 1'b1;
          fail_o.raddr = t_q;
        end
      end
      S_Q_ACC: begin
        // count each end once, then retire it
        total_d      = sat_add16(total_q, ends_rdata_i);
        ends_o.we    = 1'b1;
        ends_o.waddr = t_q;
        t_d          = fail_rdata_i;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ncount_q     <= CNT_W'(1);
      cur_q        <= '0;
      total_q      <= '0;
      built_q      <= 1'b0;
      dropped_q    <= 1'b0;
      root_valid_q <= '0;
    end else begin
      state_q      <= state_d;
      ncount_q     <= ncount_d;
      cur_q        <= cur_d;
      total_q      <= total_d;
      built_q      <= built_d;
      dropped_q    <= dropped_d;
      root_valid_q <= root_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    sym_q        <= sym_d;
    first_q      <= first_d;
    last_q       <= last_d;
    root_child_q <= root_child_d;
    idx_q        <= idx_d;
    head_q       <= head_d;
    tail_q       <= tail_d;
    now_q        <= now_d;
    f_q          <= f_d;
    t_q          <= t_d;
    newn_q       <= newn_d;
    ce_q         <= ce_d;
    res_q        <= res_d;
  end

  assign idle_o      = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

endmodule
